[design/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with async reset disable
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

[design/tcse_pkg.sv]
// package for the tcp connection state engine: constants, codes, types
// no dependencies
`default_nettype none
package tcse_pkg;
  localparam int unsigned MaxConn = 8;
  localparam int unsigned SlotW = 3;
  localparam int unsigned CountW = 4;

  localparam logic [5:0] FFin = 6'h01;
  localparam logic [5:0] FSyn = 6'h02;
  localparam logic [5:0] FRst = 6'h04;
  localparam logic [5:0] FPsh = 6'h08;
  localparam logic [5:0] FAck = 6'h10;

  localparam logic [3:0] StClosed = 4'd0;
  localparam logic [3:0] StListen = 4'd1;
  localparam logic [3:0] StSynSent = 4'd2;
  localparam logic [3:0] StSynRecv = 4'd3;
  localparam logic [3:0] StEstab = 4'd4;
  localparam logic [3:0] StLastAck = 4'd9;

  localparam logic [1:0] KindSeg = 2'd0;
  localparam logic [1:0] KindListen = 2'd1;
  localparam logic [1:0] KindConnect = 2'd2;
  localparam logic [1:0] KindSend = 2'd3;

  localparam logic [1:0] StsOk = 2'd0;
  localparam logic [1:0] StsNoMatch = 2'd1;
  localparam logic [1:0] StsFull = 2'd2;
  localparam logic [1:0] StsNotEst = 2'd3;

  localparam logic [13:0] SegMin = 14'd1040;
  localparam logic [13:0] SegMax = 14'd9000;
  localparam logic [13:0] SegReset = 14'd1400;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [1:0] status;
    logic send_valid;
    logic [5:0] flags;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [31:0] ip;
    logic [15:0] rport;
    logic [15:0] lport;
    logic [13:0] len;
    logic last;
  } result_t;
endpackage
`default_nettype wire

[design/tcse_match.sv]
// per-entry match compare, one entry per cycle under the sequencer
// depends on tcse_pkg
`default_nettype none
module tcse_match (
  input  wire logic [3:0]  st_i,
  input  wire logic [15:0] ent_lport_i,
  input  wire logic [31:0] ent_ip_i,
  input  wire logic [15:0] ent_rport_i,
  input  wire logic [15:0] lport_i,
  input  wire logic [31:0] ip_i,
  input  wire logic [15:0] rport_i,
  output logic             hit_o
);
  assign hit_o = (ent_lport_i == lport_i) &&
                 ((st_i == tcse_pkg::StListen) ||
                  (ent_ip_i == ip_i && ent_rport_i == rport_i));
endmodule
`default_nettype wire

[design/tcp_connection_state_engine.sv]
// tcp connection state engine: 8-entry connection table, one item at a time
// segment items walk the table one entry a cycle
// listen and connect items pass from idle through the act state
// send items pass through the send state, then emit one result per segment, up to 64 segments
// each result sits in an output register until taken; stall holds the sequencer
// reset clears the entry count, the sequencer and the output valid, and sets max_segment to 1400
`default_nettype none
module tcp_connection_state_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [13:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [2:0]  slot_i,
  input  wire logic [31:0] remote_ip_i,
  input  wire logic [15:0] remote_port_i,
  input  wire logic [15:0] local_port_i,
  input  wire logic [31:0] seq_in_i,
  input  wire logic [5:0]  flags_in_i,
  input  wire logic [15:0] segment_len_i,
  input  wire logic [3:0]  header_words_i,
  input  wire logic [31:0] isn_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       slot_out_o,
  output logic [1:0]       status_o,
  output logic             send_valid_o,
  output logic [5:0]       flags_out_o,
  output logic [31:0]      seq_out_o,
  output logic [31:0]      ack_out_o,
  output logic [31:0]      dest_ip_o,
  output logic [15:0]      peer_port_o,
  output logic [15:0]      host_port_o,
  output logic [13:0]      payload_len_o,
  output logic             last_o
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_ACT  = 6'b000100,
    S_FIN2 = 6'b001000,
    S_SEND = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [13:0] maxseg_q;
  logic [tcse_pkg::CountW-1:0] count_q;
  logic [tcse_pkg::SlotW-1:0] idx_q;
  logic [15:0] rem_q;
  logic [13:0] seg_q;
  logic miss_q;

  logic [3:0]  st_m [tcse_pkg::MaxConn];
  logic [15:0] lp_m [tcse_pkg::MaxConn];
  logic [31:0] ip_m [tcse_pkg::MaxConn];
  logic [15:0] rp_m [tcse_pkg::MaxConn];
  logic [31:0] sq_m [tcse_pkg::MaxConn];
  logic [31:0] ak_m [tcse_pkg::MaxConn];

  // latched input item
  logic [1:0]  kind_q;
  logic [2:0]  slot_q;
  logic [31:0] ip_q, seqin_q, isn_q;
  logic [15:0] rport_q, lport_q, len_q;
  logic [5:0]  fl_q;
  logic [5:0]  hdr_q;

  tcse_pkg::result_t res_q;
  logic ov_q;
  logic out_free;
  assign out_free = !ov_q || !out_stall_i;

  logic hit;
  tcse_match u_match (
    .st_i(st_m[idx_q]), .ent_lport_i(lp_m[idx_q]), .ent_ip_i(ip_m[idx_q]),
    .ent_rport_i(rp_m[idx_q]), .lport_i(lport_q), .ip_i(ip_q), .rport_i(rport_q),
    .hit_o(hit)
  );

  assign in_stall_o = (state_q != S_IDLE);
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  // shared subtract unit: send remainder and payload length
  logic [16:0] diff;
  logic [15:0] sub_a, sub_b;
  always_comb begin
    if (state_q == S_EMIT) begin
      sub_a = rem_q;
      sub_b = {2'b00, seg_q};
    end else begin
      sub_a = len_q;
      sub_b = {10'd0, hdr_q};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
  end

  logic [3:0] cst;
  assign cst = st_m[idx_q];
  logic [tcse_pkg::CountW-1:0] idx_ext;
  assign idx_ext = {1'b0, idx_q};

  function automatic tcse_pkg::result_t plain(logic [2:0] s, logic [1:0] sts, logic lst);
    tcse_pkg::result_t r;
    r = '0;
    r.slot = s;
    r.status = sts;
    r.last = lst;
    return r;
  endfunction

  logic emit;
  tcse_pkg::result_t res_d;
  logic wr_en;
  logic [3:0] wr_st;
  logic [31:0] wr_sq, wr_ak;
  logic wr_all;

  always_comb begin
    state_d = state_q;
    emit = 1'b0;
    res_d = res_q;
    wr_en = 1'b0;
    wr_all = 1'b0;
    wr_st = cst;
    wr_sq = sq_m[idx_q];
    wr_ak = ak_m[idx_q];
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (kind_i)
            tcse_pkg::KindSeg: state_d = S_SCAN;
            tcse_pkg::KindSend: state_d = S_SEND;
            default: state_d = S_ACT;
          endcase
        end
      end
      S_SCAN: begin
        // a miss on the last live entry, or an empty table, ends the walk with no match
        if (miss_q || idx_ext >= count_q) begin
          if (out_free) begin
            emit = 1'b1;
            res_d = plain(3'd0, tcse_pkg::StsNoMatch, 1'b1);
            state_d = S_IDLE;
          end
        end else if (hit) begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = S_IDLE;
          if (kind_q != tcse_pkg::KindSeg) begin
            if (count_q == tcse_pkg::CountW'(tcse_pkg::MaxConn)) begin
              res_d = plain(3'd0, tcse_pkg::StsFull, 1'b1);
            end else begin
              wr_all = 1'b1;
              if (kind_q == tcse_pkg::KindListen) begin
                res_d = plain(count_q[2:0], tcse_pkg::StsOk, 1'b1);
              end else begin
                res_d = '{slot: count_q[2:0], status: tcse_pkg::StsOk, send_valid: 1'b1,
                          flags: tcse_pkg::FSyn, seq: isn_q, ack: 32'd0, ip: ip_q,
                          rport: rport_q, lport: lport_q, len: 14'd0, last: 1'b1};
              end
            end
          end else begin
            res_d = plain(idx_q, tcse_pkg::StsOk, 1'b1);
            res_d.ip = ip_m[idx_q];
            res_d.rport = rp_m[idx_q];
            res_d.lport = lp_m[idx_q];
            res_d.seq = sq_m[idx_q];
            res_d.ack = ak_m[idx_q];
            if (cst == tcse_pkg::StListen && fl_q[1]) begin
              wr_en = 1'b1;
              wr_st = tcse_pkg::StSynRecv;
              wr_ak = seqin_q + 32'd1;
              wr_sq = isn_q;
              res_d.send_valid = 1'b1;
              res_d.flags = tcse_pkg::FSyn | tcse_pkg::FAck;
              res_d.ip = ip_q;
              res_d.rport = rport_q;
              res_d.seq = isn_q;
              res_d.ack = wr_ak;
            end else if (cst == tcse_pkg::StSynSent && fl_q[1] && fl_q[4]) begin
              wr_en = 1'b1;
              wr_st = tcse_pkg::StEstab;
              wr_ak = seqin_q + 32'd1;
              res_d.send_valid = 1'b1;
              res_d.flags = tcse_pkg::FAck;
              res_d.ack = wr_ak;
            end else if (cst == tcse_pkg::StSynRecv && fl_q[4]) begin
              wr_en = 1'b1;
              wr_st = tcse_pkg::StEstab;
            end else if (cst == tcse_pkg::StEstab && fl_q[0]) begin
              wr_en = 1'b1;
              wr_st = tcse_pkg::StLastAck;
              wr_ak = seqin_q + 32'd1;
              res_d.send_valid = 1'b1;
              res_d.flags = tcse_pkg::FAck;
              res_d.ack = wr_ak;
              res_d.last = 1'b0;
              state_d = S_FIN2;
            end else if (cst == tcse_pkg::StEstab && fl_q[4]) begin
              if (!diff[16] && diff[15:0] != 16'd0) begin
                wr_en = 1'b1;
                wr_ak = seqin_q + {16'd0, diff[15:0]};
                res_d.send_valid = 1'b1;
                res_d.flags = tcse_pkg::FAck;
                res_d.ack = wr_ak;
              end
            end else if (cst == tcse_pkg::StLastAck && fl_q[4]) begin
              wr_en = 1'b1;
              wr_st = tcse_pkg::StClosed;
            end
            if (!res_d.send_valid) res_d = plain(idx_q, tcse_pkg::StsOk, 1'b1);
          end
        end
      end
      S_FIN2: begin
        if (out_free) begin
          emit = 1'b1;
          res_d.flags = tcse_pkg::FFin | tcse_pkg::FAck;
          res_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SEND: begin
        if (out_free) begin
          if ({1'b0, slot_q} >= count_q) begin
            emit = 1'b1;
            res_d = plain(slot_q, tcse_pkg::StsNoMatch, 1'b1);
            state_d = S_IDLE;
          end else if (st_m[slot_q] != tcse_pkg::StEstab) begin
            emit = 1'b1;
            res_d = plain(slot_q, tcse_pkg::StsNotEst, 1'b1);
            state_d = S_IDLE;
          end else if (len_q == 16'd0) begin
            emit = 1'b1;
            res_d = plain(slot_q, tcse_pkg::StsOk, 1'b1);
            state_d = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          wr_en = 1'b1;
          res_d = '{slot: idx_q, status: tcse_pkg::StsOk, send_valid: 1'b1,
                    flags: tcse_pkg::FPsh | tcse_pkg::FAck, seq: sq_m[idx_q],
                    ack: ak_m[idx_q], ip: ip_m[idx_q], rport: rp_m[idx_q],
                    lport: lp_m[idx_q], len: 14'd0, last: 1'b0};
          if (diff[16] || diff[15:0] == 16'd0) begin
            res_d.len = rem_q[13:0];
            res_d.last = 1'b1;
            wr_sq = sq_m[idx_q] + {16'd0, rem_q};
            state_d = S_IDLE;
          end else begin
            res_d.len = seg_q;
            wr_sq = sq_m[idx_q] + {18'd0, seg_q};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      maxseg_q <= tcse_pkg::SegReset;
      ov_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) maxseg_q <= cfg_wdata_i;
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (acc) idx_q <= '0;
      else if (state_q == S_SCAN && !hit && idx_ext < count_q) begin
        // on the last entry the index holds and the miss flag ends the walk
        if (idx_ext == count_q - 4'd1 || idx_q == 3'd7) idx_q <= idx_q;
        else idx_q <= idx_q + 3'd1;
      end else if (state_q == S_SEND) idx_q <= slot_q;
      if (wr_all) count_q <= count_q + 4'd1;
    end
  end

  // set when the last live entry misses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) miss_q <= 1'b0;
    else if (acc) miss_q <= 1'b0;
    else if (state_q == S_SCAN && !hit && idx_ext < count_q &&
             (idx_ext == count_q - 4'd1 || idx_q == 3'd7)) miss_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      kind_q <= kind_i; slot_q <= slot_i; ip_q <= remote_ip_i;
      rport_q <= remote_port_i; lport_q <= local_port_i; seqin_q <= seq_in_i;
      fl_q <= flags_in_i; len_q <= segment_len_i; hdr_q <= {header_words_i, 2'b00};
      isn_q <= isn_i;
    end
    if (state_q == S_SEND) begin
      rem_q <= len_q;
      if (maxseg_q < tcse_pkg::SegMin) seg_q <= tcse_pkg::SegMin;
      else if (maxseg_q > tcse_pkg::SegMax) seg_q <= tcse_pkg::SegMax;
      else seg_q <= maxseg_q;
    end else if (state_q == S_EMIT && out_free) rem_q <= diff[15:0];
    if (emit) res_q <= res_d;
    if (wr_all) begin
      st_m[count_q[2:0]] <= (kind_q == tcse_pkg::KindListen) ?
                            tcse_pkg::StListen : tcse_pkg::StSynSent;
      lp_m[count_q[2:0]] <= lport_q;
      ip_m[count_q[2:0]] <= (kind_q == tcse_pkg::KindListen) ? 32'd0 : ip_q;
      rp_m[count_q[2:0]] <= (kind_q == tcse_pkg::KindListen) ? 16'd0 : rport_q;
      sq_m[count_q[2:0]] <= (kind_q == tcse_pkg::KindListen) ? 32'd0 : isn_q;
      ak_m[count_q[2:0]] <= 32'd0;
    end else if (wr_en) begin
      st_m[idx_q] <= wr_st;
      sq_m[idx_q] <= wr_sq;
      ak_m[idx_q] <= wr_ak;
      if (state_q == S_ACT && cst == tcse_pkg::StListen) begin
        ip_m[idx_q] <= ip_q;
        rp_m[idx_q] <= rport_q;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign slot_out_o = res_q.slot;
  assign status_o = res_q.status;
  assign send_valid_o = res_q.send_valid;
  assign flags_out_o = res_q.flags;
  assign seq_out_o = res_q.seq;
  assign ack_out_o = res_q.ack;
  assign dest_ip_o = res_q.ip;
  assign peer_port_o = res_q.rport;
  assign host_port_o = res_q.lport;
  assign payload_len_o = res_q.len;
  assign last_o = res_q.last;
endmodule
`default_nettype wire

[design/tcse_checker.sv]
// port-level checker for the connection state engine, bound to the top level
// depends on assert_macros.svh and tcse_pkg
`default_nettype none
`include "assert_macros.svh"
module tcse_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic send_valid_o,
  input wire logic [1:0] status_o,
  input wire logic [13:0] payload_len_o,
  input wire logic last_o
);
  logic in_xfer, seg_out, ctl_out, out_held, sts_ok, no_len;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign seg_out = out_valid_o && send_valid_o;
  assign ctl_out = out_valid_o && !send_valid_o;
  assign out_held = out_valid_o && out_stall_i;
  assign sts_ok = (status_o == tcse_pkg::StsOk);
  assign no_len = (payload_len_o == 14'd0);

  `ASSERT_NEXT(busy_after_accept, clk_i, rst_ni, in_xfer, in_stall_o, "not busy after accept")
  `ASSERT_IMPL(send_ok_status, clk_i, rst_ni, seg_out, sts_ok, "segment with bad status")
  `ASSERT_IMPL(ctrl_no_len, clk_i, rst_ni, ctl_out, no_len, "length on plain result")
  `ASSERT_NEXT(out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(last_o), "stalled result changed")
endmodule

bind tcp_connection_state_engine tcse_checker u_tcse_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .send_valid_o(send_valid_o),
  .status_o(status_o), .payload_len_o(payload_len_o), .last_o(last_o)
);
`default_nettype wire
